FILE: sv/pcrc_pkg.sv
// Shared types and constants for the packet CRC-16 checker.
package pcrc_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned CRC_W    = 16;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;
	localparam int unsigned M_DATA_W = 16;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	// Register index, taken from the word part of the byte address.
	typedef enum logic [0:0] {
		REG_PAYLOAD_LENGTH = 1'b0
	} reg_idx_t;

	// One verdict for a finished packet.
	typedef struct packed {
		logic [DATA_W-1:0] header_byte;
		logic              crc_ok;
	} result_t;

endpackage

FILE: sv/pcrc_regs.sv
// APB configuration register file holding the payload length.
module pcrc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pcrc_pkg::APB_AW-1:0]    paddr,
	input  logic [pcrc_pkg::APB_DW-1:0]    pwdata,
	output logic [pcrc_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	output logic [pcrc_pkg::DATA_W-1:0]    payload_length
);

	logic                        wr_en;
	pcrc_pkg::reg_idx_t          reg_idx;
	logic [pcrc_pkg::DATA_W-1:0] payload_length_q;

	assign pready  = 1'b1;
	assign reg_idx = pcrc_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				pcrc_pkg::REG_PAYLOAD_LENGTH: payload_length_q <= pwdata[pcrc_pkg::DATA_W-1:0];
				default: payload_length_q <= payload_length_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pcrc_pkg::REG_PAYLOAD_LENGTH: begin
				prdata = {{(pcrc_pkg::APB_DW-pcrc_pkg::DATA_W){1'b0}}, payload_length_q};
			end
			default: prdata = '0;
		endcase
	end

	assign payload_length = payload_length_q;

endmodule

FILE: sv/pcrc_frame.sv
// Packet framing and byte-wide CRC-16 update, one byte per cycle while in_acc is high.
module pcrc_frame (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_acc,
	input  logic [pcrc_pkg::DATA_W-1:0] data_byte,
	input  logic                        frame_last,
	input  logic [pcrc_pkg::DATA_W-1:0] payload_length,
	output logic                        res_valid,
	output pcrc_pkg::result_t           res
);

	logic [pcrc_pkg::CRC_W-1:0]  crc_q;
	logic [pcrc_pkg::POS_W-1:0]  pos_q;
	logic [pcrc_pkg::DATA_W-1:0] hdr_q;

	logic [pcrc_pkg::POS_W-1:0]  crc_start;
	logic [pcrc_pkg::POS_W-1:0]  last_pos;
	logic [pcrc_pkg::DATA_W-1:0] feed;
	logic [pcrc_pkg::DATA_W-1:0] hdr;
	logic [pcrc_pkg::CRC_W-1:0]  crc_next;
	logic                        close;

	// Eight bit steps of the MSB-first shift register, unrolled.
	always_comb begin
		logic [pcrc_pkg::CRC_W-1:0] c;
		logic                       fb;
		c = crc_q;
		for (int k = pcrc_pkg::DATA_W - 1; k >= 0; k--) begin
			fb = c[pcrc_pkg::CRC_W-1] ^ feed[k];
			c  = {c[pcrc_pkg::CRC_W-2:0], 1'b0};
			if (fb) begin
				c = c ^ pcrc_pkg::CRC_POLY;
			end
		end
		crc_next = c;
	end

	assign crc_start = {1'b0, payload_length} + pcrc_pkg::POS_W'(1);
	assign last_pos  = {1'b0, payload_length} + pcrc_pkg::POS_W'(2);
	// The two trailing CRC bytes enter inverted so a good packet leaves zero.
	assign feed      = (pos_q >= crc_start) ? ~data_byte : data_byte;
	assign close     = (pos_q >= last_pos);
	assign hdr       = (pos_q == '0) ? data_byte : hdr_q;

	assign res_valid       = in_acc && close;
	assign res.crc_ok      = (crc_next == '0);
	assign res.header_byte = hdr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= pcrc_pkg::CRC_INIT;
			pos_q <= '0;
			hdr_q <= '0;
		end else if (in_acc) begin
			hdr_q <= hdr;
			if (close || frame_last) begin
				crc_q <= pcrc_pkg::CRC_INIT;
				pos_q <= '0;
			end else begin
				crc_q <= crc_next;
				pos_q <= pos_q + pcrc_pkg::POS_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_frame_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && frame_last) |=> (pos_q == '0))
		else $error("packet position not cleared after frame end");

	a_start_crc_init: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == '0) |-> (crc_q == pcrc_pkg::CRC_INIT))
		else $error("CRC not at start value at packet start");
`endif

endmodule

FILE: sv/pcrc_out_fifo.sv
// Two-entry result queue that decouples input acceptance from output stalls.
module pcrc_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  pcrc_pkg::result_t             push_data,
	input  logic                          pop,
	output logic                          not_full,
	output logic                          not_empty,
	output pcrc_pkg::result_t             head
);

	pcrc_pkg::result_t entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_pop;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign do_pop    = pop && not_empty;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");
`endif

endmodule

FILE: sv/packet_crc16_checker.sv
// Top level of the packet CRC-16 checker: config port, framing/CRC and result queue.
//
// Channel   Dir  Handshake                 Contents
// s_*       in   s_tvalid / s_tready       tdata = data_byte, tlast = frame_last
// m_*       out  m_tvalid / m_tready       tdata = crc_ok, header_byte, zero pad
// APB       in   psel, penable, pready     register 0 at 0x0: payload_length
//
// One byte is taken per cycle while s_tready is high; a verdict is registered
// the cycle after the packet's last byte and appears on m_tvalid then.
// A two-entry result queue lets bytes keep flowing while a verdict waits;
// s_tready drops only when both entries hold untaken verdicts.
// Reset is asynchronous; the CRC restarts at 0xFFFF and the queue empties.
module packet_crc16_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pcrc_pkg::APB_AW-1:0]     paddr,
	input  logic [pcrc_pkg::APB_DW-1:0]     pwdata,
	output logic [pcrc_pkg::APB_DW-1:0]     prdata,
	output logic                            pready,
	// Input byte stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pcrc_pkg::DATA_W-1:0]     s_tdata,   // [7:0] data_byte
	input  logic                            s_tlast,   // frame_last
	// Verdict stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pcrc_pkg::M_DATA_W-1:0]   m_tdata    // [0] crc_ok, [8:1] header_byte, zero above
);

	logic [pcrc_pkg::DATA_W-1:0] payload_length;
	logic                        in_acc;
	logic                        res_valid;
	pcrc_pkg::result_t           res;
	pcrc_pkg::result_t           head;
	logic                        not_full;

	pcrc_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.payload_length (payload_length)
	);

	assign s_tready = not_full;
	assign in_acc   = s_tvalid && s_tready;

	pcrc_frame u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_acc         (in_acc),
		.data_byte      (s_tdata),
		.frame_last     (s_tlast),
		.payload_length (payload_length),
		.res_valid      (res_valid),
		.res            (res)
	);

	pcrc_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (m_tready),
		.not_full  (not_full),
		.not_empty (m_tvalid),
		.head      (head)
	);

	assign m_tdata = {{(pcrc_pkg::M_DATA_W - pcrc_pkg::DATA_W - 1){1'b0}}, head};

`ifndef NO_ASSERTIONS
	a_verdict_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> m_tvalid)
		else $error("verdict produced but no transfer offered");
`endif

endmodule

FILE: verif/packet_crc16_verdict_check.sv
// Verdict checker for the packet CRC-16 checker: predicts each packet verdict and compares.
module packet_crc16_verdict_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pcrc_pkg::APB_AW-1:0]   paddr,
	input  logic [pcrc_pkg::APB_DW-1:0]   pwdata,
	input  logic                          pready,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [pcrc_pkg::DATA_W-1:0]   s_tdata,   // [7:0] data_byte
	input  logic                          s_tlast,   // frame_last
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [pcrc_pkg::M_DATA_W-1:0] m_tdata,   // [0] crc_ok, [8:1] header_byte, zero above
	output int                            fail_count,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [pcrc_pkg::DATA_W-1:0] payload_len;
	logic [pcrc_pkg::CRC_W-1:0]  residue;
	logic [pcrc_pkg::POS_W-1:0]  pkt_pos;
	logic [pcrc_pkg::DATA_W-1:0] pkt_header;
	pcrc_pkg::result_t           verdicts_due[$];
	pcrc_pkg::result_t           got;
	pcrc_pkg::result_t           want;

	function automatic logic [pcrc_pkg::CRC_W-1:0] residue_after(
		input logic [pcrc_pkg::CRC_W-1:0] c,
		input logic [pcrc_pkg::DATA_W-1:0] d);
		logic fb;
		for (int k = pcrc_pkg::DATA_W - 1; k >= 0; k--) begin
			fb = c[pcrc_pkg::CRC_W-1] ^ d[k];
			c = {c[pcrc_pkg::CRC_W-2:0], 1'b0};
			if (fb) begin
				c = c ^ pcrc_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	// Follows one accepted byte through the packet framing and queues a verdict
	// when the byte closes a packet.
	task automatic take_byte(input logic [pcrc_pkg::DATA_W-1:0] d, input logic frame_end);
		pcrc_pkg::result_t verdict;
		if (pkt_pos == '0) begin
			pkt_header = d;
		end
		// Bytes from the first CRC position onward arrive inverted.
		if (pkt_pos >= pcrc_pkg::POS_W'(payload_len) + pcrc_pkg::POS_W'(1)) begin
			residue = residue_after(residue, ~d);
		end else begin
			residue = residue_after(residue, d);
		end
		if (pkt_pos >= pcrc_pkg::POS_W'(payload_len) + pcrc_pkg::POS_W'(2)) begin
			verdict.crc_ok = (residue == '0);
			verdict.header_byte = pkt_header;
			verdicts_due.push_back(verdict);
			residue = pcrc_pkg::CRC_INIT;
			pkt_pos = '0;
		end else begin
			pkt_pos = pkt_pos + pcrc_pkg::POS_W'(1);
		end
		if (frame_end) begin
			residue = pcrc_pkg::CRC_INIT;
			pkt_pos = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_len = '0;
			residue = pcrc_pkg::CRC_INIT;
			pkt_pos = '0;
			pkt_header = '0;
			verdicts_due.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready
				&& pcrc_pkg::reg_idx_t'(paddr[pcrc_pkg::APB_AW-1:2])
					== pcrc_pkg::REG_PAYLOAD_LENGTH) begin
				payload_len = pwdata[pcrc_pkg::DATA_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				take_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				got = pcrc_pkg::result_t'(m_tdata[pcrc_pkg::DATA_W:0]);
				if (verdicts_due.size() == 0) begin
					report_mismatch($sformatf("unexpected verdict transfer, tdata 0x%04h",
						m_tdata));
				end else begin
					want = verdicts_due.pop_front();
					if (got.crc_ok !== want.crc_ok) begin
						report_mismatch($sformatf("crc_ok %b, expected %b (header 0x%02h)",
							got.crc_ok, want.crc_ok, want.header_byte));
					end
					if (got.header_byte !== want.header_byte) begin
						report_mismatch($sformatf("header_byte 0x%02h, expected 0x%02h",
							got.header_byte, want.header_byte));
					end
					if (m_tdata[pcrc_pkg::M_DATA_W-1:pcrc_pkg::DATA_W+1] !== '0) begin
						report_mismatch($sformatf("nonzero pad bits in tdata 0x%04h", m_tdata));
					end
				end
			end
			outstanding = verdicts_due.size();
		end
	end

endmodule

FILE: verif/packet_crc16_checker_tb.sv
// Testbench top for the packet CRC-16 checker: clock, reset, stimulus and final verdict.
module packet_crc16_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 1400;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [pcrc_pkg::APB_AW-1:0]   paddr = '0;
	logic [pcrc_pkg::APB_DW-1:0]   pwdata = '0;
	logic [pcrc_pkg::APB_DW-1:0]   prdata;
	logic                          pready;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [pcrc_pkg::DATA_W-1:0]   s_tdata = '0;
	logic                          s_tlast = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [pcrc_pkg::M_DATA_W-1:0] m_tdata;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int bytes_sent = 0;
	bit jitter_on = 1'b1;

	packet_crc16_checker dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	packet_crc16_verdict_check verdict_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// The verdict side stalls at random while jitter is on.
	always @(negedge clk) begin
		m_tready <= !jitter_on || ($urandom_range(0, 99) >= 10);
	end

	// Running FCS over the bytes sent so far, used to build packets that pass.
	function automatic logic [pcrc_pkg::CRC_W-1:0] fcs_advance(
		input logic [pcrc_pkg::CRC_W-1:0] c,
		input logic [pcrc_pkg::DATA_W-1:0] d);
		logic fb;
		for (int k = pcrc_pkg::DATA_W - 1; k >= 0; k--) begin
			fb = c[pcrc_pkg::CRC_W-1] ^ d[k];
			c = {c[pcrc_pkg::CRC_W-2:0], 1'b0};
			if (fb) begin
				c = c ^ pcrc_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	// Called and returns at a falling edge.
	task automatic send_byte(input logic [pcrc_pkg::DATA_W-1:0] d, input logic frame_end);
		while (jitter_on && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tlast <= frame_end;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input pcrc_pkg::reg_idx_t idx,
		input logic [pcrc_pkg::APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain_verdicts();
		s_tvalid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// A header below zero picks a random header; a spoiled packet has one bit flipped.
	task automatic send_packet(input int plen, input int header, input bit frame_end,
		input bit spoil);
		int                          bad_at;
		logic [pcrc_pkg::CRC_W-1:0]  fcs;
		logic [pcrc_pkg::DATA_W-1:0] b;
		bad_at = spoil ? int'($urandom_range(0, plen + 2)) : -1;
		fcs = pcrc_pkg::CRC_INIT;
		for (int k = 0; k < plen + 3; k++) begin
			if (k == 0 && header >= 0) begin
				b = header[pcrc_pkg::DATA_W-1:0];
			end else if (k < plen + 1) begin
				b = pcrc_pkg::DATA_W'($urandom);
			end else if (k == plen + 1) begin
				b = ~fcs[pcrc_pkg::CRC_W-1:pcrc_pkg::DATA_W];
			end else begin
				b = ~fcs[pcrc_pkg::DATA_W-1:0];
			end
			if (k < plen + 1) begin
				fcs = fcs_advance(fcs, b);
			end
			if (k == bad_at) begin
				b = b ^ (pcrc_pkg::DATA_W'(1) << $urandom_range(0, pcrc_pkg::DATA_W - 1));
			end
			send_byte(b, frame_end && (k == plen + 2));
		end
	endtask

	// Random bytes, the last of which ends the frame.
	task automatic send_stub(input int count);
		for (int k = 0; k < count; k++) begin
			send_byte(pcrc_pkg::DATA_W'($urandom), k == count - 1);
		end
	endtask

	initial begin
		int plen;
		int frames;
		int packets;
		int roll;
		int phase;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, starting at the reset length of zero: shortest packets.
		send_packet(0, 8'h00, 1'b0, 1'b0);
		send_packet(0, 8'hFF, 1'b0, 1'b0);
		send_packet(0, -1, 1'b0, 1'b1);
		// Frame ends in the middle of a packet, then a packet closes a frame.
		send_stub(2);
		send_packet(0, 8'h5A, 1'b1, 1'b0);
		drain_verdicts();
		write_reg(pcrc_pkg::REG_PAYLOAD_LENGTH, 32'd1);
		send_packet(1, 8'hA5, 1'b0, 1'b0);
		send_packet(1, -1, 1'b1, 1'b1);
		drain_verdicts();
		// Length shrinks while a packet is half received.
		write_reg(pcrc_pkg::REG_PAYLOAD_LENGTH, 32'd2);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b0);
		drain_verdicts();
		write_reg(pcrc_pkg::REG_PAYLOAD_LENGTH, 32'd0);
		send_byte(pcrc_pkg::DATA_W'($urandom), 1'b0);
		send_packet(0, -1, 1'b1, 1'b0);
		drain_verdicts();

		// Random part: phases of frames made mostly of well-formed packets.
		phase = 0;
		while (bytes_sent < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (phase == 0 || roll < 4) begin
				plen = 255;
			end else if (phase == 1 || roll < 12) begin
				plen = 0;
			end else begin
				plen = $urandom_range(1, 12);
			end
			drain_verdicts();
			write_reg(pcrc_pkg::REG_PAYLOAD_LENGTH, pcrc_pkg::APB_DW'(plen));
			jitter_on = (phase % 6) != 3;
			frames = (plen == 255) ? 1 : $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				packets = (plen == 255) ? 1 : $urandom_range(1, 4);
				roll = $urandom_range(0, 99);
				for (int p = 0; p < packets; p++) begin
					send_packet(plen, -1, (roll >= 40) && (p == packets - 1),
						$urandom_range(0, 99) < 20);
				end
				// Some frames end on a broken tail, a few run on without an end mark.
				if (roll < 30) begin
					send_stub($urandom_range(1, plen + 2));
				end
			end
			phase++;
		end

		drain_verdicts();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/pcrc_pkg.sv
sv/pcrc_regs.sv
sv/pcrc_frame.sv
sv/pcrc_out_fifo.sv
sv/packet_crc16_checker.sv
verif/packet_crc16_verdict_check.sv
verif/packet_crc16_checker_tb.sv
